FILE: sv/lsc_pkg.sv
// Shared types and constants for the grid line-of-sight checker.
package lsc_pkg;

   localparam int MAP_SIZE = 64;
   localparam int COORD_W  = 6;
   localparam int MAP_W    = $clog2(MAP_SIZE);
   localparam int ADDR_W   = 2 * MAP_W;
   localparam int TILE_W   = MAP_W + 2;
   localparam int R_W      = COORD_W + 4;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   typedef struct packed {
      logic               mode;
      logic [COORD_W-1:0] start_x;
      logic [COORD_W-1:0] start_y;
      logic [COORD_W-1:0] end_x;
      logic [COORD_W-1:0] end_y;
      logic               walkable;
   } req_type;

   typedef struct packed {
      logic               blocked;
      logic [COORD_W-1:0] clear_x;
      logic [COORD_W-1:0] clear_y;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_SAMPLE,
      ST_PROBE,
      ST_CHECK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
   } walk_ctrl_type;

   typedef struct packed {
      logic [COORD_W-1:0]       major;
      logic signed [TILE_W-1:0] minor;
      logic                     aint;
      logic                     bint;
      logic                     xmaj;
      logic                     last;
   } sample_type;

endpackage

FILE: sv/lsc_ram.sv
// Generic single-port RAM with registered read.
module lsc_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end

endmodule

FILE: sv/lsc_walker.sv
// Sample walker: steps the major coordinate and keeps the exact minor coordinate.
module lsc_walker import lsc_pkg::*; (
   input  logic          clock,
   input  walk_ctrl_type ctrl,
   input  req_type       req,
   output sample_type    smp
);

   logic signed [COORD_W:0]   dx, dy, adx, ady, dmin, inc;
   logic                      xmaj, neg;
   logic [COORD_W-1:0]        a0, a1, b0, b1, amag;
   logic signed [R_W-1:0]     add, sum, den_s;

   logic [COORD_W-1:0]        k_ff, hi_ff;
   logic signed [TILE_W-1:0]  q_ff;
   logic signed [R_W-1:0]     r_ff;
   logic signed [COORD_W:0]   inc_ff;
   logic [COORD_W:0]          den_ff;
   logic                      first_ff, xmaj_ff;

   always_comb begin
      dx   = $signed({1'b0, req.end_x}) - $signed({1'b0, req.start_x});
      dy   = $signed({1'b0, req.end_y}) - $signed({1'b0, req.start_y});
      adx  = dx[COORD_W] ? -dx : dx;
      ady  = dy[COORD_W] ? -dy : dy;
      xmaj = adx > ady;
      a0   = xmaj ? req.start_x : req.start_y;
      a1   = xmaj ? req.end_x   : req.end_y;
      b0   = xmaj ? req.start_y : req.start_x;
      b1   = xmaj ? req.end_y   : req.end_x;
      dmin = xmaj ? dy : dx;
      neg  = xmaj ? dx[COORD_W] : dy[COORD_W];
      amag = xmaj ? adx[COORD_W-1:0] : ady[COORD_W-1:0];
      inc  = neg ? -dmin : dmin;
   end

   // first step moves half a tile, later ones a whole tile
   always_comb begin
      add   = first_ff ? R_W'(inc_ff) : (R_W'(inc_ff) <<< 1);
      sum   = r_ff + add;
      den_s = $signed({{(R_W-COORD_W-1){1'b0}}, den_ff});
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         k_ff     <= neg ? a1 : a0;
         hi_ff    <= neg ? a0 : a1;
         q_ff     <= $signed({{(TILE_W-COORD_W){1'b0}}, (neg ? b1 : b0)});
         r_ff     <= $signed({{(R_W-COORD_W){1'b0}}, amag});
         inc_ff   <= inc;
         den_ff   <= {amag, 1'b0};
         first_ff <= 1'b1;
         xmaj_ff  <= xmaj;
      end else if (ctrl.step) begin
         k_ff     <= k_ff + COORD_W'(1);
         first_ff <= 1'b0;
         if (sum >= den_s) begin
            r_ff <= sum - den_s;
            q_ff <= q_ff + TILE_W'(1);
         end else if (sum < 0) begin
            r_ff <= sum + den_s;
            q_ff <= q_ff - TILE_W'(1);
         end else begin
            r_ff <= sum;
         end
      end
   end

   always_comb begin
      smp.major = k_ff;
      smp.minor = q_ff;
      smp.aint  = !first_ff;
      smp.bint  = (r_ff == '0);
      smp.xmaj  = xmaj_ff;
      smp.last  = (k_ff == hi_ff);
   end

endmodule

FILE: sv/grid_line_of_sight_check.sv
// Top level: tile map, probe sequencer and result register.
// A write beat is written to the map while idle. A query beat walks the samples
// from the lower major end to the higher one; each sample probes one, two or
// four tiles, each probe being one map read on the single RAM port, issued in
// PROBE and checked in CHECK. The map powers up undefined; every tile a query
// touches must be written first. The result sits in an output register, so
// the next beat is taken while it waits. Tiles outside the map block the line.
module grid_line_of_sight_check import lsc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   state_type state_ff, state_in;
   req_type   req_ff;
   logic [1:0] p_ff;
   logic      blocked_ff;
   logic [COORD_W-1:0] last_x_ff, last_y_ff;
   logic      rsp_valid_ff;
   rsp_type   rsp_ff;

   walk_ctrl_type walk_ctrl;
   sample_type    smp;

   logic req_acc, same_end, slot_free, sample_done, xint, yint, oob;
   logic signed [TILE_W-1:0] fx, fy, tx, ty;
   logic ram_we, ram_rd;
   logic [ADDR_W-1:0] ram_addr;

   lsc_walker u_walker (
      .clock (clock),
      .ctrl  (walk_ctrl),
      .req   (req_ff),
      .smp   (smp)
   );

   lsc_ram #(.WIDTH(1), .DEPTH(MAP_SIZE * MAP_SIZE)) u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (req_data.walkable),
      .rd_data (ram_rd)
   );

   always_comb begin
      req_acc  = req_valid && !req_stall;
      same_end = (req_data.start_x == req_data.end_x) &&
                 (req_data.start_y == req_data.end_y);
      slot_free = !rsp_valid_ff || !rsp_stall;
      xint = smp.xmaj ? smp.aint : smp.bint;
      yint = smp.xmaj ? smp.bint : smp.aint;
      fx = smp.xmaj ? $signed({{(TILE_W-COORD_W){1'b0}}, smp.major}) : smp.minor;
      fy = smp.xmaj ? smp.minor : $signed({{(TILE_W-COORD_W){1'b0}}, smp.major});
      tx = fx - ((xint && !p_ff[0]) ? TILE_W'(1) : TILE_W'(0));
      ty = fy - ((yint && !p_ff[1]) ? TILE_W'(1) : TILE_W'(0));
      oob = tx[TILE_W-1] || ty[TILE_W-1] ||
            (tx >= $signed(TILE_W'(MAP_SIZE))) || (ty >= $signed(TILE_W'(MAP_SIZE)));
      sample_done = p_ff[0] && p_ff[1];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc && req_data.mode == MODE_QUERY) begin
               state_in = same_end ? ST_DONE : ST_SETUP;
            end
         end
         ST_SETUP:  state_in = ST_SAMPLE;
         ST_SAMPLE: state_in = ST_PROBE;
         ST_PROBE:  state_in = oob ? ST_DONE : ST_CHECK;
         ST_CHECK: begin
            if (!ram_rd) begin
               state_in = ST_DONE;
            end else if (!sample_done) begin
               state_in = ST_PROBE;
            end else begin
               state_in = smp.last ? ST_DONE : ST_SAMPLE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall      = (state_ff != ST_IDLE);
      walk_ctrl.load = (state_ff == ST_SETUP);
      walk_ctrl.step = (state_ff == ST_CHECK) && ram_rd && sample_done && !smp.last;
      ram_we         = (state_ff == ST_IDLE) && req_valid &&
                       (req_data.mode == MODE_WRITE);
      if (state_ff == ST_IDLE) begin
         ram_addr = {req_data.start_y[MAP_W-1:0], req_data.start_x[MAP_W-1:0]};
      end else begin
         ram_addr = {ty[MAP_W-1:0], tx[MAP_W-1:0]};
      end
      rsp_valid = rsp_valid_ff;
      rsp_data  = rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         last_x_ff    <= '0;
         last_y_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_DONE && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == ST_CHECK && ram_rd) begin
            last_x_ff <= tx[COORD_W-1:0];
            last_y_ff <= ty[COORD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_acc) begin
         req_ff     <= req_data;
         blocked_ff <= 1'b0;
      end
      if (state_ff == ST_SAMPLE) begin
         p_ff <= {!yint, !xint};
      end
      if (state_ff == ST_PROBE && oob) begin
         blocked_ff <= 1'b1;
      end
      if (state_ff == ST_CHECK) begin
         if (!ram_rd) begin
            blocked_ff <= 1'b1;
         end else if (!p_ff[0]) begin
            p_ff[0] <= 1'b1;
         end else if (!p_ff[1]) begin
            p_ff <= {1'b1, !xint};
         end
      end
      if (state_ff == ST_DONE && slot_free) begin
         rsp_ff.blocked <= blocked_ff;
         rsp_ff.clear_x <= last_x_ff;
         rsp_ff.clear_y <= last_y_ff;
      end
   end

endmodule
